// ===== hw/rtl/lse_pkg.sv =====
// lse_pkg: shared types and codes for the LSB stego extractor.
// Used by the interfaces and all lse_* modules; no dependencies.
package lse_pkg;

  localparam int SAMPLE_W = 8;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 32;
  localparam int NIB_W    = 4;
  localparam int KIND_W   = 2;
  localparam int BCNT_W   = 3;
  localparam int HIDX_W   = 2;

  localparam logic [KIND_W-1:0] KIND_LENGTH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ID      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd2;

  localparam logic [BCNT_W-1:0] BCNT_LAST = 3'd7;
  localparam logic [HIDX_W-1:0] HIDX_LAST = 2'd3;

  typedef enum logic [3:0] {
    PH_LENGTH  = 4'b0001,
    PH_ID      = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic valid;
    logic lsb;
    logic sof;
  } smp_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] byte_value;
    logic [LEN_W-1:0]  payload_length;
    logic [NIB_W-1:0]  digit_high;
    logic [NIB_W-1:0]  digit_low;
    logic              last_payload;
  } res_t;

endpackage

// ===== hw/rtl/lse_in_if.sv =====
// lse_in_if: cover sample channel (valid/ready plus sample word).
// Depends on lse_pkg.
interface lse_in_if import lse_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] cover_sample;
  logic                start_of_image;

  modport source(output valid, cover_sample, start_of_image, input ready);
  modport sink(input valid, cover_sample, start_of_image, output ready);
endinterface

// ===== hw/rtl/lse_out_if.sv =====
// lse_out_if: extracted result channel (valid/ready plus result word).
// Depends on lse_pkg.
interface lse_out_if import lse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] byte_value;
  logic [LEN_W-1:0]  payload_length;
  logic [NIB_W-1:0]  digit_high;
  logic [NIB_W-1:0]  digit_low;
  logic              last_payload;

  modport source(output valid, kind, byte_value, payload_length, digit_high,
                 digit_low, last_payload, input ready);
  modport sink(input valid, kind, byte_value, payload_length, digit_high,
               digit_low, last_payload, output ready);
endinterface

// ===== hw/rtl/lse_in_stage.sv =====
// lse_in_stage: input register holding one sample lsb and restart flag.
// Depends on lse_pkg, lse_in_if.
module lse_in_stage import lse_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  lse_in_if.sink        in_ch,
  input  logic          adv,
  output smp_t          smp
);

  logic smp_v_r, smp_v_nxt;
  logic lsb_r, sof_r;
  logic load;

  assign in_ch.ready = !smp_v_r || adv;
  assign load        = in_ch.valid && in_ch.ready;
  assign smp_v_nxt   = load || (smp_v_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_v_r <= 1'b0;
    end else begin
      smp_v_r <= smp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lsb_r <= in_ch.cover_sample[0];
      sof_r <= in_ch.start_of_image;
    end
  end

  assign smp = '{valid: smp_v_r, lsb: lsb_r, sof: sof_r};

endmodule

// ===== hw/rtl/lse_core.sv =====
// lse_core: extraction state (bit gather, header, payload count) and result logic.
// Depends on lse_pkg.
module lse_core import lse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  smp_t smp,
  input  logic out_free,
  output logic adv,
  output logic fire,
  output res_t res
);

  logic [BCNT_W-1:0] bit_count_r, bit_count_nxt;
  logic [BYTE_W-1:0] bit_shift_r, bit_shift_nxt;
  phase_t            phase_r, phase_nxt;
  logic [HIDX_W-1:0] hidx_r, hidx_nxt;
  logic [LEN_W-1:0]  len_acc_r, len_acc_nxt;
  logic [LEN_W-1:0]  remain_r, remain_nxt;

  logic [BCNT_W-1:0] bc_cur;
  logic [BYTE_W-1:0] bs_cur;
  phase_t            ph_cur;
  logic [HIDX_W-1:0] hi_cur;
  logic [LEN_W-1:0]  la_cur;
  logic [LEN_W-1:0]  rm_cur;
  logic [BYTE_W-1:0] byte_w;
  logic [LEN_W-1:0]  la_new;
  logic [LEN_W-1:0]  rm_dec;
  logic              produce;

  always_comb begin
    bc_cur = bit_count_r;
    bs_cur = bit_shift_r;
    ph_cur = phase_r;
    hi_cur = hidx_r;
    la_cur = len_acc_r;
    rm_cur = remain_r;
    if (smp.sof) begin
      bc_cur = '0;
      bs_cur = '0;
      ph_cur = PH_LENGTH;
      hi_cur = '0;
      la_cur = '0;
      rm_cur = '0;
    end

    byte_w = bs_cur | (BYTE_W'(smp.lsb) << bc_cur);
    la_new = la_cur | (LEN_W'(byte_w) << {hi_cur, 3'b000});
    rm_dec = rm_cur - LEN_W'(1);

    bit_count_nxt = bc_cur;
    bit_shift_nxt = bs_cur;
    phase_nxt     = ph_cur;
    hidx_nxt      = hi_cur;
    len_acc_nxt   = la_cur;
    remain_nxt    = rm_cur;
    produce       = 1'b0;
    res           = '{kind: KIND_LENGTH, byte_value: byte_w, payload_length: '0,
                      digit_high: '0, digit_low: '0, last_payload: 1'b0};

    if (ph_cur != PH_DONE) begin
      if (bc_cur != BCNT_LAST) begin
        bit_count_nxt = bc_cur + BCNT_W'(1);
        bit_shift_nxt = byte_w;
      end else begin
        bit_count_nxt = '0;
        bit_shift_nxt = '0;
        case (ph_cur)
          PH_LENGTH: begin
            len_acc_nxt = la_new;
            if (hi_cur != HIDX_LAST) begin
              hidx_nxt = hi_cur + HIDX_W'(1);
            end else begin
              hidx_nxt               = '0;
              remain_nxt             = la_new;
              phase_nxt              = PH_ID;
              produce                = 1'b1;
              res.kind               = KIND_LENGTH;
              res.payload_length     = la_new;
              res.last_payload       = (la_new == '0);
            end
          end
          PH_ID: begin
            produce        = 1'b1;
            res.kind       = KIND_ID;
            res.digit_high = byte_w[BYTE_W-1 -: NIB_W];
            res.digit_low  = byte_w[NIB_W-1:0];
            if (hi_cur != HIDX_LAST) begin
              hidx_nxt = hi_cur + HIDX_W'(1);
            end else begin
              hidx_nxt  = '0;
              phase_nxt = (rm_cur == '0) ? PH_DONE : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            produce    = 1'b1;
            res.kind   = KIND_PAYLOAD;
            remain_nxt = rm_dec;
            if (rm_dec == '0) begin
              res.last_payload = 1'b1;
              phase_nxt        = PH_DONE;
            end
          end
          default: begin
            phase_nxt = ph_cur;
          end
        endcase
      end
    end
  end

  assign adv  = smp.valid && (!produce || out_free);
  assign fire = adv && produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r <= '0;
      bit_shift_r <= '0;
      phase_r     <= PH_LENGTH;
      hidx_r      <= '0;
      len_acc_r   <= '0;
      remain_r    <= '0;
    end else if (adv) begin
      bit_count_r <= bit_count_nxt;
      bit_shift_r <= bit_shift_nxt;
      phase_r     <= phase_nxt;
      hidx_r      <= hidx_nxt;
      len_acc_r   <= len_acc_nxt;
      remain_r    <= remain_nxt;
    end
  end

endmodule

// ===== hw/rtl/lse_out_reg.sv =====
// lse_out_reg: result register driving the output channel.
// Depends on lse_pkg, lse_out_if.
module lse_out_reg import lse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  res_t      res,
  output logic      out_free,
  lse_out_if.source out_ch
);

  logic out_v_r, out_v_nxt;
  res_t res_r;

  assign out_free  = !out_v_r || out_ch.ready;
  assign out_v_nxt = fire || (out_v_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.byte_value     = res_r.byte_value;
  assign out_ch.payload_length = res_r.payload_length;
  assign out_ch.digit_high     = res_r.digit_high;
  assign out_ch.digit_low      = res_r.digit_low;
  assign out_ch.last_payload   = res_r.last_payload;

endmodule

// ===== hw/rtl/lsb_stego_extractor.sv =====
// LSB stego extractor: takes one cover sample word per cycle, gathers sample lsbs
// into bytes, reports the 32-bit length, four ID bytes and then the payload bytes.
// A sample passes an input register and a result register from accept to result.
// One sample is taken every cycle unless stalled; a result comes at most every
// eighth sample, and in_ch.ready drops only while a sample that completes a byte
// waits for the result register to be drained. Depends on lse_pkg and lse_* files.
module lsb_stego_extractor import lse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lse_in_if.sink    in_ch,
  lse_out_if.source out_ch
);

  smp_t smp;
  res_t res;
  logic adv;
  logic fire;
  logic out_free;

  lse_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .smp   (smp)
  );

  lse_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .smp      (smp),
    .out_free (out_free),
    .adv      (adv),
    .fire     (fire),
    .res      (res)
  );

  lse_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

  a_ready_only_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (smp.valid && !out_free))
    else $error("input stalled without a held sample");

  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_ch.valid)
    else $error("result lost");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.kind == KIND_LENGTH || out_ch.kind == KIND_ID ||
                      out_ch.kind == KIND_PAYLOAD))
    else $error("bad result kind");

  a_id_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_ID) |->
      (!out_ch.last_payload && out_ch.payload_length == '0))
    else $error("id word carries length fields");

endmodule
